/* rtl/dsw_pkg.sv */
// Package for the dice sum way counter: field widths, bounds, modulus,
// microcode word format and the control program ROM.
// No dependencies.
package dsw_pkg;

  localparam int unsigned MAX_DICE   = 32;
  localparam int unsigned MAX_FACES  = 32;
  localparam int unsigned MAX_TARGET = 1024;

  localparam int unsigned DICE_W   = 6;
  localparam int unsigned FACES_W  = 6;
  localparam int unsigned TARGET_W = 11;
  localparam int unsigned WAYS_W   = 30;

  localparam int unsigned ROW_LEN = MAX_TARGET + 1;
  localparam int unsigned IDX_W   = $clog2(ROW_LEN);

  localparam logic [WAYS_W-1:0] WAYS_MOD = 30'd1000000007;

  typedef logic [DICE_W-1:0]   dice_t;
  typedef logic [FACES_W-1:0]  faces_t;
  typedef logic [TARGET_W-1:0] target_t;
  typedef logic [WAYS_W-1:0]   ways_t;
  typedef logic [IDX_W-1:0]    idx_t;

  typedef enum logic [2:0] {
    ACT_NOP,
    ACT_LOAD,
    ACT_CHECK,
    ACT_ROW_START,
    ACT_CELL,
    ACT_ROW_END,
    ACT_OUT
  } act_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_REQ,
    COND_BAD,
    COND_MORE_CELLS,
    COND_MORE_ROWS,
    COND_OUT_BUSY
  } cond_e;

  typedef logic [2:0] upc_t;

  localparam upc_t UPC_WAIT      = 3'd0;
  localparam upc_t UPC_CHECK     = 3'd1;
  localparam upc_t UPC_ROW_START = 3'd2;
  localparam upc_t UPC_CELL      = 3'd3;
  localparam upc_t UPC_ROW_END   = 3'd4;
  localparam upc_t UPC_OUT       = 3'd5;
  localparam upc_t UPC_LAST      = UPC_OUT;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    upc_t  jmp;
  } uword_t;

  // One cell request from the sequencer to the row datapath.
  typedef struct packed {
    logic valid;
    idx_t wr_addr;
    idx_t rd_addr;
    logic rd_zero;
    idx_t back_addr;
    logic back_use;
    logic back_zero;
    logic first;
    logic sel;
    logic last;
    logic win_clr;
  } issue_t;

  // Taken jump when cond holds, else fall through (last step wraps).
  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    case (pc)
      UPC_WAIT:      w = '{act: ACT_LOAD,      cond: COND_NO_REQ,     jmp: UPC_WAIT};
      UPC_CHECK:     w = '{act: ACT_CHECK,     cond: COND_BAD,        jmp: UPC_OUT};
      UPC_ROW_START: w = '{act: ACT_ROW_START, cond: COND_NEVER,      jmp: UPC_WAIT};
      UPC_CELL:      w = '{act: ACT_CELL,      cond: COND_MORE_CELLS, jmp: UPC_CELL};
      UPC_ROW_END:   w = '{act: ACT_ROW_END,   cond: COND_MORE_ROWS,  jmp: UPC_ROW_START};
      UPC_OUT:       w = '{act: ACT_OUT,       cond: COND_OUT_BUSY,   jmp: UPC_OUT};
      default:       w = '{act: ACT_NOP,       cond: COND_ALWAYS,     jmp: UPC_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* rtl/dsw_if.sv */
// Request and result channel interfaces for the dice sum way counter.
// Depends on dsw_pkg.
interface dsw_req_if;
  logic             valid;
  logic             ready;
  dsw_pkg::dice_t   num_dice;
  dsw_pkg::faces_t  faces;
  dsw_pkg::target_t target_sum;

  modport source (output valid, output num_dice, output faces, output target_sum,
                  input ready);
  modport sink (input valid, input num_dice, input faces, input target_sum,
                output ready);
endinterface

interface dsw_res_if;
  logic           valid;
  logic           ready;
  dsw_pkg::ways_t ways;
  logic           range_error;

  modport source (output valid, output ways, output range_error, input ready);
  modport sink (input valid, input ways, input range_error, output ready);
endinterface

/* rtl/dsw_dp.sv */
// Row datapath: ping-pong row memories and the sliding-window adder mod 1e9+7.
// Depends on dsw_pkg.
module dsw_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dsw_pkg::issue_t issue_i,
  output logic            done_o,
  output dsw_pkg::ways_t  ways_o
);
  import dsw_pkg::*;

  ways_t  mem_a [ROW_LEN];
  ways_t  mem_b [ROW_LEN];
  ways_t  a_rd_q, a_bk_q, b_rd_q, b_bk_q;
  issue_t s_q;
  logic   s_valid_q;
  ways_t  win_q, win_d;
  ways_t  v1, v2, sum1;
  logic [WAYS_W:0] acc, diff;
  logic   we_a, we_b;

  assign we_a = s_valid_q & s_q.sel;
  assign we_b = s_valid_q & ~s_q.sel;

  always_ff @(posedge clk_i) begin
    a_rd_q <= mem_a[issue_i.rd_addr];
    a_bk_q <= mem_a[issue_i.back_addr];
    if (we_a) begin
      mem_a[s_q.wr_addr] <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_rd_q <= mem_b[issue_i.rd_addr];
    b_bk_q <= mem_b[issue_i.back_addr];
    if (we_b) begin
      mem_b[s_q.wr_addr] <= win_d;
    end
  end

  // cell zero holds 1 before the first die and 0 after; first row is empty elsewhere
  always_comb begin
    if (s_q.rd_zero) begin
      v1 = s_q.first ? ways_t'(1) : '0;
    end else if (s_q.first) begin
      v1 = '0;
    end else begin
      v1 = s_q.sel ? b_rd_q : a_rd_q;
    end
    if (s_q.back_zero) begin
      v2 = s_q.first ? ways_t'(1) : '0;
    end else if (s_q.first) begin
      v2 = '0;
    end else begin
      v2 = s_q.sel ? b_bk_q : a_bk_q;
    end
  end

  always_comb begin
    acc = {1'b0, win_q} + {1'b0, v1};
    if (acc >= {1'b0, WAYS_MOD}) begin
      acc = acc - {1'b0, WAYS_MOD};
    end
    sum1 = acc[WAYS_W-1:0];
    diff = {1'b0, sum1} - {1'b0, v2};
    if (diff[WAYS_W]) begin
      diff = diff + {1'b0, WAYS_MOD};
    end
    win_d = s_q.back_use ? diff[WAYS_W-1:0] : sum1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= issue_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= issue_i;
    if (issue_i.win_clr) begin
      win_q <= '0;
    end else if (s_valid_q) begin
      win_q <= win_d;
    end
  end

  assign done_o = s_valid_q & s_q.last;
  assign ways_o = win_d;

endmodule

/* rtl/dice_sum_way_counter_top.sv */
// Top level of the dice sum way counter: microcoded sequencer and result register.
// Depends on dsw_pkg, dsw_if.sv and dsw_dp.
//
// Counts the ordered dice sequences that reach target_sum, modulo 1000000007, one
// request at a time. Each die is one pass over cells 1..target_sum through a
// single window adder fed by two row memories, one cell per cycle; a request out
// of range answers with ways = 0 and range_error set. The result sits in an output
// register until taken; the next request is accepted once the previous result has
// been loaded there.
module dice_sum_way_counter_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  dsw_req_if.sink    req_i,
  dsw_res_if.source  res_o
);
  import dsw_pkg::*;

  upc_t    upc_q, upc_d;
  uword_t  uw;
  logic    cond_hit;
  dice_t   dice_q, dice_d;
  faces_t  faces_q, faces_d;
  target_t target_q, target_d;
  dice_t   d_q, d_d;
  idx_t    t_q, t_d;
  logic    first_q, first_d;
  logic    sel_q, sel_d;
  ways_t   res_ways_q, res_ways_d;
  logic    res_err_q, res_err_d;
  logic    out_valid_q, out_valid_d;
  ways_t   out_ways_q, out_ways_d;
  logic    out_err_q, out_err_d;
  logic    bad, out_busy, req_acc;
  issue_t  issue;
  logic    dp_done;
  ways_t   dp_ways;
  idx_t    back_addr;

  assign uw = ucode(upc_q);

  assign bad = (dice_q == '0) || (dice_q > dice_t'(MAX_DICE)) ||
               (faces_q == '0) || (faces_q > faces_t'(MAX_FACES)) ||
               (target_q == '0) || (target_q > target_t'(MAX_TARGET));
  assign out_busy = out_valid_q & ~res_o.ready;
  assign req_i.ready = (uw.act == ACT_LOAD);
  assign req_acc = req_i.valid & req_i.ready;

  always_comb begin
    case (uw.cond)
      COND_NEVER:      cond_hit = 1'b0;
      COND_ALWAYS:     cond_hit = 1'b1;
      COND_NO_REQ:     cond_hit = ~req_i.valid;
      COND_BAD:        cond_hit = bad;
      COND_MORE_CELLS: cond_hit = (t_q != idx_t'(target_q));
      COND_MORE_ROWS:  cond_hit = (d_q != dice_q);
      COND_OUT_BUSY:   cond_hit = out_busy;
      default:         cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_hit) begin
      upc_d = uw.jmp;
    end else if (upc_q == UPC_LAST) begin
      upc_d = UPC_WAIT;
    end else begin
      upc_d = upc_q + 3'd1;
    end
  end

  assign back_addr = t_q - idx_t'(faces_q) - idx_t'(1);

  always_comb begin
    issue.valid     = (uw.act == ACT_CELL);
    issue.wr_addr   = t_q;
    issue.rd_addr   = t_q - idx_t'(1);
    issue.rd_zero   = (t_q == idx_t'(1));
    issue.back_addr = back_addr;
    issue.back_use  = (t_q > idx_t'(faces_q));
    issue.back_zero = (back_addr == '0);
    issue.first     = first_q;
    issue.sel       = sel_q;
    issue.last      = (t_q == idx_t'(target_q)) && (d_q == dice_q);
    issue.win_clr   = (uw.act == ACT_ROW_START);
  end

  always_comb begin
    dice_d      = dice_q;
    faces_d     = faces_q;
    target_d    = target_q;
    d_d         = d_q;
    t_d         = t_q;
    first_d     = first_q;
    sel_d       = sel_q;
    res_ways_d  = dp_done ? dp_ways : res_ways_q;
    res_err_d   = res_err_q;
    out_valid_d = out_valid_q & ~res_o.ready;
    out_ways_d  = out_ways_q;
    out_err_d   = out_err_q;
    case (uw.act)
      ACT_LOAD: begin
        if (req_acc) begin
          dice_d   = req_i.num_dice;
          faces_d  = req_i.faces;
          target_d = req_i.target_sum;
        end
      end
      ACT_CHECK: begin
        d_d        = dice_t'(1);
        first_d    = 1'b1;
        sel_d      = 1'b0;
        res_ways_d = '0;
        res_err_d  = bad;
      end
      ACT_ROW_START: begin
        t_d = idx_t'(1);
      end
      ACT_CELL: begin
        t_d = t_q + idx_t'(1);
      end
      ACT_ROW_END: begin
        d_d     = d_q + dice_t'(1);
        first_d = 1'b0;
        sel_d   = ~sel_q;
      end
      ACT_OUT: begin
        if (!out_busy) begin
          out_valid_d = 1'b1;
          out_ways_d  = res_ways_q;
          out_err_d   = res_err_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= UPC_WAIT;
      out_valid_q <= 1'b0;
      first_q     <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      out_valid_q <= out_valid_d;
      first_q     <= first_d;
      sel_q       <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dice_q     <= dice_d;
    faces_q    <= faces_d;
    target_q   <= target_d;
    d_q        <= d_d;
    t_q        <= t_d;
    res_ways_q <= res_ways_d;
    res_err_q  <= res_err_d;
    out_ways_q <= out_ways_d;
    out_err_q  <= out_err_d;
  end

  dsw_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .done_o  (dp_done),
    .ways_o  (dp_ways)
  );

  assign res_o.valid       = out_valid_q;
  assign res_o.ways        = out_ways_q;
  assign res_o.range_error = out_err_q;

endmodule

/* tb/sv/tb_top.sv */
// Testbench for dice_sum_way_counter_top: directed and random requests with a
// scoreboard that predicts each count by a row-by-row window sum.
// Depends on dsw_pkg, dsw_if.sv and the RTL of the block.
module tb_top;
  import dsw_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 150000;
  localparam int unsigned DRAIN_CYCLES   = 50;
  localparam int unsigned RANDOM_COUNT   = 80;
  localparam int unsigned CALM_COUNT     = 20;

  typedef struct {
    ways_t ways;
    logic  range_error;
  } ways_result_t;

  class way_scoreboard;
    ways_result_t expected_q[$];
    ways_t        prev_row[ROW_LEN];
    ways_t        cur_row[ROW_LEN];
    int unsigned  mismatches;
    int unsigned  requests;
    int unsigned  range_errors;
    int unsigned  zero_ways;
    int unsigned  max_cells;

    function new();
      mismatches   = 0;
      requests     = 0;
      range_errors = 0;
      zero_ways    = 0;
      max_cells    = 0;
    endfunction

    function void clear_rows();
      for (int i = 0; i < ROW_LEN; i++) begin
        prev_row[i] = '0;
        cur_row[i]  = '0;
      end
    endfunction

    function ways_t count_sequences(int unsigned dice, int unsigned faces,
                                    int unsigned target);
      longint unsigned win;
      longint unsigned modulus;
      modulus = longint'(WAYS_MOD);
      clear_rows();
      prev_row[0] = 1;
      for (int unsigned d = 1; d <= dice; d++) begin
        win = 0;
        cur_row[0] = '0;
        for (int unsigned t = 1; t <= target; t++) begin
          win += prev_row[t-1];
          if (t >= faces + 1) begin
            win += modulus;
            win -= prev_row[t-1-faces];
          end
          win = win % modulus;
          cur_row[t] = ways_t'(win);
        end
        prev_row = cur_row;
      end
      return cur_row[target];
    endfunction

    function void note_request(dice_t dice, faces_t faces, target_t target);
      ways_result_t exp_res;
      logic         bad;
      bad = (dice == 0) || (dice > MAX_DICE) || (faces == 0) || (faces > MAX_FACES) ||
            (target == 0) || (target > MAX_TARGET);
      requests++;
      if (bad) begin
        clear_rows();
        exp_res.ways        = '0;
        exp_res.range_error = 1'b1;
        range_errors++;
      end else begin
        exp_res.ways        = count_sequences(dice, faces, target);
        exp_res.range_error = 1'b0;
        if (exp_res.ways == 0) zero_ways++;
        if (dice * target > max_cells) max_cells = dice * target;
      end
      expected_q.push_back(exp_res);
    endfunction

    function void check_result(ways_t ways, logic range_error);
      ways_result_t exp_res;
      if (expected_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: ways %0d range_error %0b", ways, range_error);
        mismatches++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (ways !== exp_res.ways) begin
        if (mismatches < 10)
          $display("ways mismatch: expected %0d got %0d", exp_res.ways, ways);
        mismatches++;
      end
      if (range_error !== exp_res.range_error) begin
        if (mismatches < 10)
          $display("range_error mismatch: expected %0b got %0b",
                   exp_res.range_error, range_error);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic calm;

  dsw_req_if req_if ();
  dsw_res_if res_if ();

  dice_sum_way_counter_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  way_scoreboard sb;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic send_request(dice_t dice, faces_t faces, target_t target);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.num_dice   <= dice;
    req_if.faces      <= faces;
    req_if.target_sum <= target;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(dice, faces, target);
  endtask

  task automatic send_random_request();
    int unsigned pick;
    int unsigned d;
    int unsigned f;
    int unsigned t;
    int unsigned hi;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // noise over the full field widths
      d = $urandom_range(0, 63);
      f = $urandom_range(0, 63);
      t = $urandom_range(0, 2047);
    end else if (pick < 12) begin
      d = $urandom_range(16, 32);
      f = $urandom_range(1, 32);
      t = $urandom_range(512, 1024);
    end else if (pick < 20) begin
      // unreachable target, just outside the reachable span
      d = $urandom_range(1, 8);
      f = $urandom_range(1, 8);
      if (d > 1 && $urandom_range(0, 1) == 0) t = d - 1;
      else t = d * f + $urandom_range(1, 4);
    end else begin
      d  = $urandom_range(1, 8);
      f  = $urandom_range(1, 32);
      hi = (d * f > 160) ? 160 : d * f;
      t  = $urandom_range(d, hi);
    end
    send_request(dice_t'(d), faces_t'(f), target_t'(t));
  endtask

  // result side: random stalls, checks every taken result
  initial begin
    int unsigned stall;
    stall = 0;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) sb.check_result(res_if.ways, res_if.range_error);
      if (stall > 0) begin
        stall--;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 12) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request or result moved for %0d cycles", quiet);
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    calm              = 1'b0;
    rst_ni           <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.num_dice   <= '0;
    req_if.faces      <= '0;
    req_if.target_sum <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(6'd1, 6'd1, 11'd1);
    send_request(6'd32, 6'd32, 11'd1024);
    send_request(6'd32, 6'd32, 11'd32);
    send_request(6'd1, 6'd32, 11'd32);
    send_request(6'd32, 6'd1, 11'd32);
    send_request(6'd3, 6'd6, 11'd10);
    send_request(6'd2, 6'd6, 11'd13);
    send_request(6'd5, 6'd6, 11'd4);
    send_request(6'd1, 6'd32, 11'd33);
    send_request(6'd0, 6'd6, 11'd6);
    send_request(6'd6, 6'd0, 11'd6);
    send_request(6'd6, 6'd6, 11'd0);
    send_request(6'd33, 6'd6, 11'd6);
    send_request(6'd6, 6'd33, 11'd6);
    send_request(6'd6, 6'd6, 11'd1025);
    send_request(6'd63, 6'd63, 11'd2047);
    send_request(6'd0, 6'd0, 11'd0);
    send_request(6'd24, 6'd32, 11'd400);
    send_request(6'd10, 6'd10, 11'd55);
    send_request(6'd2, 6'd2, 11'd3);
    send_request(6'd32, 6'd32, 11'd1);

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (i >= RANDOM_COUNT - CALM_COUNT) calm = 1'b1;
      send_random_request();
    end
    req_if.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d requests: %0d out of range, %0d with no way to the target.",
             sb.requests, sb.range_errors, sb.zero_ways);
    $display("Largest table swept: %0d cells; %0d mismatches.", sb.max_cells, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
